@@ hdl/keyframe_track_lerp_sampler_defines.svh @@
// Assertion macros used by the sampler back end (kts_back).
`ifndef KEYFRAME_TRACK_LERP_SAMPLER_DEFINES_SVH
`define KEYFRAME_TRACK_LERP_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KTS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KTS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/kts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_pkg
// Types and constants shared by the keyframe track sampler modules.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int unsigned MaxKeys  = 64;
  localparam int unsigned IdxW     = $clog2(MaxKeys);
  localparam int unsigned CountW   = 7;
  localparam int unsigned QueueDepth = 2;

  // Input transfer payload
  typedef struct packed {
    logic               mode;
    logic [5:0]         key_index;
    logic [31:0]        time_value;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
  } kts_in_t;

  // Result transfer payload
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]         segment;
    logic               not_found;
  } kts_out_t;

  // Work classes decided by the front end
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_SEARCH = 2'd2
  } kts_kind_e;

  localparam logic MODE_LOAD = 1'b0;

  // Queue entry between front and back
  typedef struct packed {
    kts_kind_e   kind;
    logic [5:0]  key_index;
    logic [31:0] time_value;
    logic [95:0] vec;
    logic [5:0]  segs;
  } kts_entry_t;

  // Queue push side
  typedef struct packed {
    logic       valid;
    kts_entry_t entry;
  } kts_push_t;

endpackage

@@ hdl/keyframe_track_lerp_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_track_lerp_sampler
// Keyframe track store with linear interpolation sampling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): mode 0 loads one
//   keyframe into slot key_index, mode 1 samples the track at time_value.
//   Loads give no result; each sample gives one transfer on the output channel
//   (out_valid_o / out_stall_i / out_data_o).
//   cfg_we_i writes key_count; write it only while the block is idle.
//   The front end queues up to two items, so input transfers go on while a
//   result waits on a stalled receiver; a full queue raises in_stall_o.
//   A sample on a single-key track skips the segment search and the divider.
//   The segment search walks key times with one memory read per cycle, and
//   the factor divider is bit-serial. Samples run one at a time.
//   A held result blocks the back end until the receiver takes it.
//   Reset clears the queue, the result valid flag, the cached segment and
//   sets key_count to 1; keyframe contents are undefined until loaded.
// ----------------------------------------------------------------------------
module keyframe_track_lerp_sampler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kts_pkg::kts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kts_pkg::kts_out_t out_data_o
);
  import kts_pkg::*;

  kts_push_t  push;
  kts_entry_t head;
  logic       q_full, q_empty, q_pop;

  kts_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .q_full_i (q_full),
    .push_o   (push)
  );

  kts_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .head_o  (head)
  );

  kts_back u_back (
    .clk_i, .rst_ni,
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (q_pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

@@ hdl/kts_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_front
// Accepts input transfers, holds key_count and classifies each item.
// ----------------------------------------------------------------------------
module kts_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kts_pkg::kts_in_t in_data_i,
  input  logic            q_full_i,
  output kts_pkg::kts_push_t push_o
);
  import kts_pkg::*;

  logic [CountW-1:0] key_count_q;
  logic [CountW-1:0] key_count_d;
  logic [CountW-1:0] n_eff;
  logic [CountW-1:0] segs_w;

  // Configuration register
  always_comb begin
    key_count_d = cfg_we_i ? cfg_wdata_i : key_count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= CountW'(1);
    end else begin
      key_count_q <= key_count_d;
    end
  end

  // Clamp count to 1..MaxKeys
  always_comb begin
    if (key_count_q == '0) begin
      n_eff = CountW'(1);
    end else if (key_count_q > CountW'(MaxKeys)) begin
      n_eff = CountW'(MaxKeys);
    end else begin
      n_eff = key_count_q;
    end
    segs_w = n_eff - CountW'(1);
  end

  // Classify and push
  always_comb begin
    in_stall_o               = q_full_i;
    push_o.valid             = in_valid_i && !q_full_i;
    push_o.entry.key_index   = in_data_i.key_index;
    push_o.entry.time_value  = in_data_i.time_value;
    push_o.entry.vec         = {in_data_i.key_x, in_data_i.key_y, in_data_i.key_z};
    push_o.entry.segs        = segs_w[5:0];
    if (in_data_i.mode == MODE_LOAD) begin
      push_o.entry.kind = KIND_LOAD;
    end else if (segs_w == '0) begin
      push_o.entry.kind = KIND_SINGLE;
    end else begin
      push_o.entry.kind = KIND_SEARCH;
    end
  end

endmodule

@@ hdl/kts_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module kts_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kts_pkg::kts_push_t   push_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output kts_pkg::kts_entry_t  head_o
);
  import kts_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  kts_entry_t         mem_q [QueueDepth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]      cnt_q, cnt_d;
  logic               do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
    empty_o = (cnt_q == '0);
    head_o  = mem_q[rd_q];
    do_push = push_i.valid && !full_o;
    do_pop  = pop_i && !empty_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hdl/kts_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kts_back
// Keyframe store, segment search, factor divider and component blend.
// ----------------------------------------------------------------------------
`include "keyframe_track_lerp_sampler_defines.svh"
module kts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  kts_pkg::kts_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kts_pkg::kts_out_t   out_data_o
);
  import kts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SINGLE, ST_FWD_PRIME, ST_FWD, ST_RESCAN, ST_FETCH0, ST_FETCH1,
    ST_DIV, ST_FACT, ST_MUL, ST_ADD, ST_OUT
  } state_e;

  // Keyframe memories
  logic [31:0] key_times   [MaxKeys];
  logic [95:0] key_vectors [MaxKeys];
  logic [31:0] times_rd_q;
  logic [95:0] vec_rd_q;
  logic        mem_we;
  logic [IdxW-1:0] rd_addr;

  state_e        state_q, state_d;
  logic [IdxW-1:0] a_q, cache_q, cache_d, lo_q, lo_d, last_q, last_d, segs_q, segs_d;
  logic [IdxW-1:0] seg_w;
  logic [31:0]   t_q, t_d, prev_q, prev_d, t0_q, t0_d;
  logic [95:0]   v0_q, v0_d, v1_q, v1_d;
  logic          found_q, found_d;
  // divider
  logic [31:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [47:0]   dq_q, dq_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          fneg_q, fneg_d, dzero_q, dzero_d;
  logic [32:0]   rem_sh;
  logic [33:0]   trial;
  logic [32:0]   num_w, den_w, magn_w;
  // blend
  logic signed [31:0] f_q, f_d;
  logic [1:0]    c_q, c_d;
  logic [64:0]   prod_q, prod_d, rnd_w;
  logic          sneg_q, sneg_d;
  logic [31:0]   a_cq, a_cd, ca, cb;
  logic [32:0]   diff_w, magd_w;
  logic [31:0]   magf_w;
  logic [48:0]   stepm_w;
  logic signed [51:0] step_w, sum_w;
  logic [31:0]   sat_w;
  logic [31:0]   rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  // output register
  logic          out_valid_q, out_valid_d;
  kts_out_t      out_q, out_d;

  // Memory port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_times[head_i.key_index[IdxW-1:0]]   <= head_i.time_value;
      key_vectors[head_i.key_index[IdxW-1:0]] <= head_i.vec;
    end
    times_rd_q <= key_times[rd_addr];
    vec_rd_q   <= key_vectors[rd_addr];
  end

  // Component pick for current blend step
  always_comb begin
    case (c_q)
      2'd0:    begin ca = v0_q[95:64]; cb = v1_q[95:64]; end
      2'd1:    begin ca = v0_q[63:32]; cb = v1_q[63:32]; end
      default: begin ca = v0_q[31:0];  cb = v1_q[31:0];  end
    endcase
    diff_w = {cb[31], cb} - {ca[31], ca};
    magd_w = diff_w[32] ? (33'd0 - diff_w) : diff_w;
    magf_w = f_q[31] ? (32'd0 - f_q) : f_q;
    rnd_w  = prod_q + 65'h0FFFF;
    stepm_w = sneg_q ? rnd_w[64:16] : prod_q[64:16];
    step_w = sneg_q ? (52'sd0 - $signed({3'b000, stepm_w}))
                    : $signed({3'b000, stepm_w});
    sum_w  = $signed({{20{a_cq[31]}}, a_cq}) + step_w;
    if (sum_w > 52'sh7FFFFFFF) begin
      sat_w = 32'h7FFF_FFFF;
    end else if (sum_w < -52'sh80000000) begin
      sat_w = 32'h8000_0000;
    end else begin
      sat_w = sum_w[31:0];
    end
  end

  // Divider step and span setup
  always_comb begin
    rem_sh = {rem_q, dq_q[47]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
    num_w  = {1'b0, t_q} - {1'b0, t0_q};
    den_w  = {1'b0, times_rd_q} - {1'b0, t0_q};
    magn_w = num_w[32] ? (33'd0 - num_w) : num_w;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cache_d = cache_q; lo_d = lo_q; last_d = last_q; segs_d = segs_q;
    t_d = t_q; prev_d = prev_q; t0_d = t0_q; v0_d = v0_q; v1_d = v1_q;
    found_d = found_q;
    rem_d = rem_q; dvs_d = dvs_q; dq_d = dq_q; cnt_d = cnt_q;
    fneg_d = fneg_q; dzero_d = dzero_q;
    f_d = f_q; c_d = c_q; prod_d = prod_q; sneg_d = sneg_q; a_cd = a_cq;
    rx_d = rx_q; ry_d = ry_q; rz_d = rz_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d   = out_q;
    pop_o   = 1'b0;
    mem_we  = 1'b0;
    rd_addr = a_q;
    seg_w   = a_q - IdxW'(1);

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          t_d    = head_i.time_value;
          segs_d = head_i.segs;
          case (head_i.kind)
            KIND_LOAD: begin
              mem_we = 1'b1;
            end
            KIND_SINGLE: begin
              rd_addr = '0;
              state_d = ST_SINGLE;
            end
            default: begin
              if (cache_q < head_i.segs) begin
                last_d  = cache_q;
                rd_addr = cache_q;
                state_d = ST_FWD_PRIME;
              end else begin
                last_d  = head_i.segs - IdxW'(1);
                rd_addr = IdxW'(1);
                state_d = ST_RESCAN;
              end
            end
          endcase
        end
      end
      ST_SINGLE: begin
        rx_d    = vec_rd_q[95:64];
        ry_d    = vec_rd_q[63:32];
        rz_d    = vec_rd_q[31:0];
        lo_d    = '0;
        found_d = 1'b1;
        state_d = ST_OUT;
      end
      ST_FWD_PRIME: begin
        prev_d  = times_rd_q;
        rd_addr = a_q + IdxW'(1);
        state_d = ST_FWD;
      end
      ST_FWD: begin
        if (t_q < times_rd_q && t_q >= prev_q) begin
          lo_d = seg_w; found_d = 1'b1; cache_d = seg_w;
          rd_addr = seg_w; state_d = ST_FETCH0;
        end else if (a_q == segs_q) begin
          rd_addr = IdxW'(1); state_d = ST_RESCAN;
        end else begin
          prev_d = times_rd_q; rd_addr = a_q + IdxW'(1);
        end
      end
      ST_RESCAN: begin
        if (t_q < times_rd_q) begin
          lo_d = seg_w; found_d = 1'b1; cache_d = seg_w;
          rd_addr = seg_w; state_d = ST_FETCH0;
        end else if (seg_w == last_q) begin
          lo_d = '0; found_d = 1'b0;
          rd_addr = '0; state_d = ST_FETCH0;
        end else begin
          rd_addr = a_q + IdxW'(1);
        end
      end
      ST_FETCH0: begin
        t0_d    = times_rd_q;
        v0_d    = vec_rd_q;
        rd_addr = lo_q + IdxW'(1);
        state_d = ST_FETCH1;
      end
      ST_FETCH1: begin
        v1_d    = vec_rd_q;
        dvs_d   = den_w[32] ? (32'd0 - den_w[31:0]) : den_w[31:0];
        dq_d    = {magn_w[31:0], 16'h0000};
        rem_d   = '0;
        cnt_d   = '0;
        fneg_d  = num_w[32] ^ den_w[32];
        dzero_d = (den_w == '0);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = trial[33] ? rem_sh[31:0] : trial[31:0];
        dq_d  = {dq_q[46:0], ~trial[33]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          state_d = ST_FACT;
        end
      end
      ST_FACT: begin
        if (dzero_q) begin
          f_d = '0;
        end else if (fneg_q) begin
          f_d = (dq_q > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - dq_q[31:0]);
        end else begin
          f_d = (dq_q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : dq_q[31:0];
        end
        c_d     = 2'd0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = {32'd0, magd_w} * {33'd0, magf_w};
        sneg_d  = diff_w[32] ^ f_q[31];
        a_cd    = ca;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        case (c_q)
          2'd0:    rx_d = sat_w;
          2'd1:    ry_d = sat_w;
          default: rz_d = sat_w;
        endcase
        if (c_q == 2'd2) begin
          state_d = ST_OUT;
        end else begin
          c_d     = c_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.out_x       = rx_q;
          out_d.out_y       = ry_q;
          out_d.out_z       = rz_q;
          out_d.segment     = 6'(lo_q);
          out_d.not_found   = !found_q;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cache_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cache_q     <= cache_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    a_q <= rd_addr;
    lo_q <= lo_d; last_q <= last_d; segs_q <= segs_d;
    t_q <= t_d; prev_q <= prev_d; t0_q <= t0_d; v0_q <= v0_d; v1_q <= v1_d;
    found_q <= found_d;
    rem_q <= rem_d; dvs_q <= dvs_d; dq_q <= dq_d; cnt_q <= cnt_d;
    fneg_q <= fneg_d; dzero_q <= dzero_d;
    f_q <= f_d; c_q <= c_d; prod_q <= prod_d; sneg_q <= sneg_d; a_cq <= a_cd;
    rx_q <= rx_d; ry_q <= ry_d; rz_q <= rz_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KTS_ASSERT_NOW(a_pop_idle, pop_o, state_q == ST_IDLE, "queue pop outside idle")
  `KTS_ASSERT_NOW(a_cache_hold, (state_q != ST_FWD && state_q != ST_RESCAN),
                  cache_d == cache_q, "cache changed outside search")
  `KTS_ASSERT_NEXT(a_div_len, (state_q == ST_DIV && cnt_q == 6'd47),
                   state_q == ST_FACT, "divider did not finish after 48 steps")
  `KTS_ASSERT_NOW(a_nf_seg, (out_valid_o && out_data_o.not_found),
                  out_data_o.segment == '0, "not_found result off segment 0")

endmodule
